// ===== hdl/crc8c_pkg.sv =====
// ----------------------------------------------------------------------------
// crc8c_pkg
// Shared types, register indexes and bit helpers for the CRC-8 checker.
// ----------------------------------------------------------------------------
package crc8c_pkg;

	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_POLYNOMIAL    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INIT_VALUE    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FINAL_XOR     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_REFLECT_INPUT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_REFLECT_CHECK = 3'd4;

	localparam logic [7:0] POLYNOMIAL_RST = 8'h07;
	localparam logic [7:0] INIT_VALUE_RST = 8'h00;
	localparam logic [7:0] FINAL_XOR_RST  = 8'h00;

	typedef struct packed {
		logic [7:0] polynomial;
		logic [7:0] init_value;
		logic [7:0] final_xor;
		logic       reflect_input;
		logic       reflect_check;
	} cfg_t;

	// one queue entry: byte already in processing bit order, checksum in compare order
	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_byte;
		logic       last_byte;
		logic [7:0] expected_sum;
	} qent_t;

	function automatic logic [7:0] bit_rev8(input logic [7:0] v);
		logic [7:0] r;
		for (int i = 0; i < 8; i++) begin
			r[i] = v[7-i];
		end
		return r;
	endfunction

	// eight MSB-first shift steps
	function automatic logic [7:0] crc8_byte(input logic [7:0] r_in, input logic [7:0] poly);
		logic [7:0] r;
		r = r_in;
		for (int k = 0; k < 8; k++) begin
			if (r[7]) begin
				r = {r[6:0], 1'b0} ^ poly;
			end else begin
				r = {r[6:0], 1'b0};
			end
		end
		return r;
	endfunction

endpackage

// ===== hdl/crc8c_front.sv =====
// ----------------------------------------------------------------------------
// crc8c_front
// Input side: takes stream transactions and reorders bits per configuration
// before handing entries to the queue.
// ----------------------------------------------------------------------------
module crc8c_front (
	input  logic           s_axis_tvalid,
	output logic           s_axis_tready,
	input  logic [15:0]    s_axis_tdata,   // [7:0] data_byte, [15:8] expected_sum
	input  logic           s_axis_tlast,   // last_byte
	input  logic           s_axis_tuser,   // first_byte
	input  crc8c_pkg::cfg_t cfg,
	input  logic           q_full,
	output logic           q_push,
	output crc8c_pkg::qent_t q_wdata
);
	import crc8c_pkg::*;

	assign s_axis_tready = ~q_full;
	assign q_push        = s_axis_tvalid & ~q_full;

	always_comb begin
		q_wdata.data_byte    = cfg.reflect_input ? bit_rev8(s_axis_tdata[7:0]) : s_axis_tdata[7:0];
		q_wdata.first_byte   = s_axis_tuser;
		q_wdata.last_byte    = s_axis_tlast;
		q_wdata.expected_sum = cfg.reflect_check ? bit_rev8(s_axis_tdata[15:8])
		                                         : s_axis_tdata[15:8];
	end

endmodule

// ===== hdl/crc8c_queue.sv =====
// ----------------------------------------------------------------------------
// crc8c_queue
// Small FIFO between front and back; push and pop in the same cycle.
// ----------------------------------------------------------------------------
module crc8c_queue #(
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  crc8c_pkg::qent_t wdata,
	output logic             full,
	input  logic             pop,
	output logic             rvalid,
	output crc8c_pkg::qent_t rdata
);
	import crc8c_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	qent_t         mem_q [DEPTH];
	logic [AW-1:0] wptr_q;
	logic [AW-1:0] rptr_q;
	logic [CW-1:0] cnt_q;

	assign full   = (cnt_q == FULL_CNT);
	assign rvalid = (cnt_q != '0);
	assign rdata  = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == LAST_PTR) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == LAST_PTR) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== hdl/crc8c_back.sv =====
// ----------------------------------------------------------------------------
// crc8c_back
// Execution side: CRC register update per byte, result register on last byte.
// ----------------------------------------------------------------------------
module crc8c_back (
	input  logic             clk,
	input  logic             arst_n,
	input  crc8c_pkg::cfg_t  cfg,
	input  logic             q_rvalid,
	input  crc8c_pkg::qent_t q_rdata,
	output logic             q_pop,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [7:0]       m_axis_tdata,   // [7:0] crc_value
	output logic             m_axis_tuser    // check_ok
);
	import crc8c_pkg::*;

	logic [7:0] crc_q;
	logic [7:0] crc_nxt;
	logic [7:0] result;
	logic       out_valid_q;
	logic [7:0] out_crc_q;
	logic       out_ok_q;
	logic       out_free;

	assign out_free = ~out_valid_q | m_axis_tready;
	assign q_pop    = q_rvalid & (~q_rdata.last_byte | out_free);

	always_comb begin
		crc_nxt = crc8_byte((q_rdata.first_byte ? cfg.init_value : crc_q) ^ q_rdata.data_byte,
		                    cfg.polynomial);
		result  = crc_nxt ^ cfg.final_xor;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				crc_q <= crc_nxt;
			end
			if (q_pop && q_rdata.last_byte) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && q_rdata.last_byte) begin
			out_crc_q <= result;
			out_ok_q  <= (q_rdata.expected_sum == result);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_crc_q;
	assign m_axis_tuser  = out_ok_q;

endmodule

// ===== hdl/crc8_configurable_check.sv =====
// ----------------------------------------------------------------------------
// crc8_configurable_check
// CRC-8 over a byte stream with settable polynomial, init, final XOR and
// bit reflection; emits the checksum and a match flag on the last byte.
//
// Input stream: one message byte per transaction, tuser = first byte (reloads
// the CRC register with init_value), tlast = last byte, tdata[15:8] = the
// received checksum, used only with tlast. Output stream: one transaction per
// last byte, tdata = CRC XOR final_xor, tuser = checksum match.
// Configuration: cfg_index selects polynomial, init_value, final_xor,
// reflect_input, reflect_check (0..4); other indexes are ignored. Write only
// while no transaction is in flight.
// Throughput: one byte per cycle while not stalled; the eight shift steps are one pass of logic.
// Path to output valid: the queue write at the accepting edge, then the CRC update
// writing the result register when the entry is popped.
// Reset: CRC register cleared to zero, registers to their defaults, queue empty.
// Output stall: the result register holds; bytes without tlast keep flowing,
// and the queue fills until a pending last byte can be written out.
// ----------------------------------------------------------------------------
module crc8_configurable_check #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [15:0]                     s_axis_tdata,  // [7:0] data_byte, [15:8] expected_sum
	input  logic                            s_axis_tlast,  // last_byte
	input  logic                            s_axis_tuser,  // first_byte
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [7:0]                      m_axis_tdata,  // [7:0] crc_value
	output logic                            m_axis_tuser,  // check_ok
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [crc8c_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                      cfg_data
);
	import crc8c_pkg::*;

	cfg_t  cfg_q;
	logic  q_full;
	logic  q_push;
	logic  q_pop;
	logic  q_rvalid;
	qent_t q_wdata;
	qent_t q_rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.polynomial    <= POLYNOMIAL_RST;
			cfg_q.init_value    <= INIT_VALUE_RST;
			cfg_q.final_xor     <= FINAL_XOR_RST;
			cfg_q.reflect_input <= 1'b0;
			cfg_q.reflect_check <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_POLYNOMIAL:    cfg_q.polynomial    <= cfg_data;
				REG_INIT_VALUE:    cfg_q.init_value    <= cfg_data;
				REG_FINAL_XOR:     cfg_q.final_xor     <= cfg_data;
				REG_REFLECT_INPUT: cfg_q.reflect_input <= cfg_data[0];
				REG_REFLECT_CHECK: cfg_q.reflect_check <= cfg_data[0];
				default: ;
			endcase
		end
	end

	crc8c_front u_front (
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.s_axis_tuser  (s_axis_tuser),
		.cfg           (cfg_q),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_wdata       (q_wdata)
	);

	crc8c_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.rvalid (q_rvalid),
		.rdata  (q_rdata)
	);

	crc8c_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.q_rvalid      (q_rvalid),
		.q_rdata       (q_rdata),
		.q_pop         (q_pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for crc8_configurable_check. Messages are fed as byte
// transactions in random bursts and gaps, while the result side stalls on a
// changing pattern. Each accepted byte updates a local CRC-8 tracker. Every
// last byte queues the checksum and match flag that the block must return.
// The registers are rewritten between phases, only after the block has gone
// idle. Register values include the all-zero and all-one extremes.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import crc8c_pkg::*;

	localparam int QUIET_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 8;
	localparam int NUM_PHASES   = 7;
	localparam int PHASE_ITEMS  = 200;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_byte;
		logic       last_byte;
		logic [7:0] expected_sum;
	} msg_byte_t;

	typedef struct packed {
		logic [7:0] crc_value;
		logic       check_ok;
	} crc_result_t;

	typedef enum int {SUM_MATCH, SUM_NEAR, SUM_RANDOM, SUM_ZERO, SUM_ONES} sum_kind_e;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [15:0]          s_axis_tdata = '0;
	logic                 s_axis_tlast = 1'b0;
	logic                 s_axis_tuser = 1'b0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [7:0]           m_axis_tdata;
	logic                 m_axis_tuser;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [7:0]           cfg_data = '0;

	cfg_t        cfg_shadow = '{polynomial: POLYNOMIAL_RST, init_value: INIT_VALUE_RST,
		final_xor: FINAL_XOR_RST, reflect_input: 1'b0, reflect_check: 1'b0};
	logic [7:0]  crc_state = 8'h00;
	logic [7:0]  gen_crc = 8'h00;
	msg_byte_t   byte_tx_q[$];
	crc_result_t crc_expect_q[$];
	msg_byte_t   bus_item;
	logic        bus_loaded = 1'b0;
	int          burst_left = 1;
	int          gap_left = 0;
	int          queued_cnt = 0;
	int          mismatch_cnt = 0;
	int          quiet_cycles = 0;
	int          stall_tick = 0;
	int          stall_mode = 0;

	crc8_configurable_check u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [7:0] mirror8(input logic [7:0] v);
		logic [7:0] r;
		r = {<<{v}};
		return r;
	endfunction

	// register after folding one byte in, MSB first
	function automatic logic [7:0] crc_after(input logic [7:0] start, input logic [7:0] d);
		logic [7:0] r;
		r = start ^ (cfg_shadow.reflect_input ? mirror8(d) : d);
		repeat (8) begin
			r = r[7] ? ({r[6:0], 1'b0} ^ cfg_shadow.polynomial) : {r[6:0], 1'b0};
		end
		return r;
	endfunction

	function automatic void crc_track_byte(input msg_byte_t it);
		crc_result_t res;
		logic [7:0]  sum;
		crc_state = crc_after(it.first_byte ? cfg_shadow.init_value : crc_state, it.data_byte);
		if (it.last_byte) begin
			res.crc_value = crc_state ^ cfg_shadow.final_xor;
			sum = cfg_shadow.reflect_check ? mirror8(it.expected_sum) : it.expected_sum;
			res.check_ok = (sum == res.crc_value);
			crc_expect_q.push_back(res);
		end
	endfunction

	task automatic log_mismatch(input string msg);
		if (mismatch_cnt < 10) begin
			$display("[%0t] mismatch: %s", $realtime, msg);
		end
		mismatch_cnt++;
	endtask

	task automatic queue_byte(input logic [7:0] d, input logic f, input logic l,
			input sum_kind_e kind);
		msg_byte_t  it;
		logic [7:0] good;
		gen_crc = crc_after(f ? cfg_shadow.init_value : gen_crc, d);
		good = gen_crc ^ cfg_shadow.final_xor;
		if (cfg_shadow.reflect_check) begin
			good = mirror8(good);
		end
		it.data_byte = d;
		it.first_byte = f;
		it.last_byte = l;
		case (kind)
			SUM_MATCH: it.expected_sum = good;
			SUM_NEAR:  it.expected_sum = good ^ (8'h01 << $urandom_range(0, 7));
			SUM_ZERO:  it.expected_sum = 8'h00;
			SUM_ONES:  it.expected_sum = 8'hFF;
			default:   it.expected_sum = 8'($urandom);
		endcase
		byte_tx_q.push_back(it);
		queued_cnt++;
	endtask

	task automatic queue_message();
		int        len;
		int        shape;
		sum_kind_e kind;
		logic      f;
		logic      l;
		len = ($urandom_range(0, 15) == 0) ? $urandom_range(17, 48) : $urandom_range(1, 8);
		shape = $urandom_range(0, 19);
		case ($urandom_range(0, 3))
			0, 1:    kind = SUM_MATCH;
			2:       kind = SUM_NEAR;
			default: kind = SUM_RANDOM;
		endcase
		for (int i = 0; i < len; i++) begin
			f = (i == 0);
			l = (i == len - 1);
			if (shape == 0) begin
				f = 1'b0;
			end else if (shape == 1) begin
				l = 1'b0;
			end else if (shape == 2) begin
				f = 1'($urandom_range(0, 1));
				l = 1'($urandom_range(0, 1));
			end
			queue_byte(8'($urandom), f, l, l ? kind : SUM_RANDOM);
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_POLYNOMIAL:    cfg_shadow.polynomial = val;
			REG_INIT_VALUE:    cfg_shadow.init_value = val;
			REG_FINAL_XOR:     cfg_shadow.final_xor = val;
			REG_REFLECT_INPUT: cfg_shadow.reflect_input = val[0];
			REG_REFLECT_CHECK: cfg_shadow.reflect_check = val[0];
			default: ;
		endcase
	endtask

	// sender holds off until every result is back and the pipe has emptied
	task automatic drain_results();
		while (byte_tx_q.size() != 0 || bus_loaded || crc_expect_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	always @(posedge clk) begin : drive_proc
		logic take_next;
		if (arst_n) begin
			take_next = !bus_loaded;
			if (s_axis_tvalid && s_axis_tready) begin
				crc_track_byte(bus_item);
				bus_loaded = 1'b0;
				take_next = 1'b1;
			end
			if (take_next) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (byte_tx_q.size() != 0) begin
					bus_item = byte_tx_q.pop_front();
					bus_loaded = 1'b1;
					s_axis_tdata <= {bus_item.expected_sum, bus_item.data_byte};
					s_axis_tlast <= bus_item.last_byte;
					s_axis_tuser <= bus_item.first_byte;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 40);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
					end
				end
				s_axis_tvalid <= bus_loaded;
			end
		end
	end

	always @(posedge clk) begin : check_proc
		crc_result_t want;
		logic        rdy;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (crc_expect_q.size() == 0) begin
					log_mismatch($sformatf("unexpected result crc_value=%02h check_ok=%0b",
						m_axis_tdata, m_axis_tuser));
				end else begin
					want = crc_expect_q.pop_front();
					if (m_axis_tdata !== want.crc_value) begin
						log_mismatch($sformatf("crc_value expected %02h got %02h",
							want.crc_value, m_axis_tdata));
					end
					if (m_axis_tuser !== want.check_ok) begin
						log_mismatch($sformatf("check_ok expected %0b got %0b (crc %02h)",
							want.check_ok, m_axis_tuser, want.crc_value));
					end
				end
			end
			stall_tick++;
			if (stall_tick % 64 == 0) begin
				stall_mode = $urandom_range(0, 3);
			end
			case (stall_mode)
				0:       rdy = 1'b1;
				1:       rdy = (stall_tick % 4 != 0);
				2:       rdy = 1'($urandom_range(0, 1));
				default: rdy = (stall_tick % 8 >= 6);
			endcase
			m_axis_tready <= rdy;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
					|| (cfg_valid && cfg_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles == QUIET_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin
		cfg_t next_cfg;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// reset defaults; register starts at zero with no first byte seen
		queue_byte(8'h00, 1'b0, 1'b1, SUM_MATCH);
		queue_byte(8'hFF, 1'b1, 1'b1, SUM_NEAR);
		for (int i = 0; i < 9; i++) begin
			queue_byte(8'h31 + 8'(i), i == 0, i == 8, (i == 8) ? SUM_MATCH : SUM_ONES);
		end
		queue_byte(8'h80, 1'b1, 1'b0, SUM_ONES);
		queue_byte(8'h01, 1'b0, 1'b0, SUM_ZERO);
		queue_byte(8'hAA, 1'b0, 1'b1, SUM_RANDOM);
		queue_byte(8'h55, 1'b1, 1'b1, SUM_ZERO);
		queue_byte(8'h00, 1'b1, 1'b1, SUM_ONES);
		queue_byte(8'hFF, 1'b1, 1'b1, SUM_MATCH);

		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			drain_results();
			case (phase)
				0: next_cfg = '0;
				1: next_cfg = '1;
				2: next_cfg = '{polynomial: 8'h31, init_value: 8'hFF, final_xor: 8'h00,
					reflect_input: 1'b1, reflect_check: 1'b1};
				default: next_cfg = cfg_t'($bits(cfg_t)'($urandom));
			endcase
			write_reg(REG_POLYNOMIAL, next_cfg.polynomial);
			write_reg(REG_INIT_VALUE, next_cfg.init_value);
			write_reg(REG_FINAL_XOR, next_cfg.final_xor);
			write_reg(REG_REFLECT_INPUT, {7'($urandom), next_cfg.reflect_input});
			write_reg(REG_REFLECT_CHECK, {7'($urandom), next_cfg.reflect_check});
			// unmapped index must leave everything alone
			write_reg(REG_REFLECT_CHECK + CFG_IDX_W'($urandom_range(1, 3)), 8'($urandom));
			if (phase == 1) begin
				queue_byte(8'h00, 1'b1, 1'b1, SUM_MATCH);
				queue_byte(8'hFF, 1'b0, 1'b1, SUM_MATCH);
			end
			queued_cnt = 0;
			while (queued_cnt < PHASE_ITEMS) begin
				queue_message();
			end
		end
		drain_results();

		if (mismatch_cnt == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
